>>> design/hqz_pkg.sv
// shared types, fixed-point constants and latencies of the hex point quantizer
package hqz_pkg;

    localparam int COORD_W        = 56;
    localparam int FRAC_BITS      = 16;
    localparam int RES_W          = 4;
    localparam int MAX_RESOLUTION = 8;
    localparam int P7_W           = 12;

    localparam int MULQ_LAT = 4;
    localparam int ROT_LAT  = MULQ_LAT + 1;
    localparam int LAT_LAT  = MULQ_LAT + 1;
    localparam int SNAP_LAT = MULQ_LAT + 4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [31:0]               t_coef;

    // unsigned Q2.30 coefficients
    localparam t_coef K_COS_T     = 32'd1014590657;
    localparam t_coef K_SIN_T     = 32'd351464513;
    localparam t_coef K_COS30     = 32'd929887698;
    localparam t_coef K_HALF      = 32'd536870912;
    localparam t_coef K_SQRT3     = 32'd1859775395;
    localparam t_coef K_SQRT7     = 32'd2840853839;
    localparam t_coef K_INV_SIN60 = 32'd1239850263;
    localparam t_coef K_ONE       = 32'd1073741824;
    localparam t_coef K_ZERO      = 32'd0;

    localparam logic REG_GRID_RES = 1'b0;

    // 7 to the power of half the resolution
    function automatic logic [P7_W-1:0] pow7(input logic [RES_W-2:0] half_res);
        logic [P7_W-1:0] v;
        unique case (half_res)
            3'd0:    v = 12'd1;
            3'd1:    v = 12'd7;
            3'd2:    v = 12'd49;
            3'd3:    v = 12'd343;
            default: v = 12'd2401;
        endcase
        return v;
    endfunction

endpackage

>>> design/hqz_mulq.sv
// signed by unsigned Q2.30 constant product, rounded half away from zero, four stages
module hqz_mulq (
    input  logic           i_clk,
    input  logic           i_en,
    input  hqz_pkg::t_coord i_a,
    input  hqz_pkg::t_coef  i_c,
    output hqz_pkg::t_coord o_p
);
    import hqz_pkg::*;

    logic               r_neg1, r_neg2, r_neg3;
    logic [COORD_W-1:0] r_mag;
    t_coef              r_c;
    logic [COORD_W-1:0] r_ph;
    logic [63:0]        r_pl;
    logic [COORD_W-1:0] r_p;
    t_coord             r_out;

    logic [COORD_W-1:0] w_ph;
    logic [64:0]        w_rnd;
    logic [COORD_W-1:0] w_sum;

    assign w_ph  = COORD_W'(r_mag[COORD_W-1:32]) * COORD_W'(r_c);
    assign w_rnd = {1'b0, r_pl} + (65'd1 << 29);
    assign w_sum = (r_ph << 2) + COORD_W'(w_rnd >> 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[COORD_W-1];
            r_mag  <= i_a[COORD_W-1] ? COORD_W'(-i_a) : COORD_W'(i_a);
            r_c    <= i_c;
            r_neg2 <= r_neg1;
            r_ph   <= w_ph;
            r_pl   <= 64'(r_mag[31:0]) * 64'(r_c);
            r_neg3 <= r_neg2;
            r_p    <= w_sum;
            r_out  <= r_neg3 ? -t_coord'(r_p) : t_coord'(r_p);
        end
    end

    assign o_p = r_out;

endmodule

>>> design/hqz_snap.sv
// class I hex lattice snap with quadrant mirroring, eight stages
module hqz_snap (
    input  logic            i_clk,
    input  logic            i_en,
    input  hqz_pkg::t_coord i_x,
    input  hqz_pkg::t_coord i_y,
    output hqz_pkg::t_coord o_i,
    output hqz_pkg::t_coord o_j
);
    import hqz_pkg::*;

    localparam int CW = FRAC_BITS + 3;
    localparam logic [CW-1:0] C_ONE = CW'(1) << FRAC_BITS;

    t_coord r_a1, r_a2;
    logic   r_sx, r_sy;
    t_coord r_d_a1 [1:MULQ_LAT];
    logic   r_d_sx [1:MULQ_LAT];
    logic   r_d_sy [1:MULQ_LAT];
    t_coord w_x2;
    t_coord r_x1, r_x2;
    logic   r_sx6, r_sy6;
    t_coord r_i, r_j;
    logic   r_sx7, r_sy7;
    t_coord r_oi, r_oj;

    logic [CW-1:0] w_r1, w_r2;
    logic          w_di, w_dj;
    t_coord        w_m1, w_m2;

    hqz_mulq u_x2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_a2),
        .i_c   (K_INV_SIN60),
        .o_p   (w_x2)
    );

    assign w_r1 = CW'(r_x1[FRAC_BITS-1:0]);
    assign w_r2 = CW'(r_x2[FRAC_BITS-1:0]);
    assign w_m1 = r_x1 >>> FRAC_BITS;
    assign w_m2 = r_x2 >>> FRAC_BITS;

    // pick the nearest center from the fractional parts
    always_comb begin
        if (2 * w_r1 < C_ONE) begin
            if (3 * w_r1 < C_ONE) begin
                w_di = 1'b0;
                w_dj = !(2 * w_r2 < C_ONE + w_r1);
            end else begin
                w_dj = !(w_r2 < C_ONE - w_r1);
                w_di = (C_ONE - w_r1 <= w_r2) && (w_r2 < 2 * w_r1);
            end
        end else begin
            if (3 * w_r1 < 2 * C_ONE) begin
                w_dj = !(w_r2 < C_ONE - w_r1);
                w_di = !((2 * w_r1 - C_ONE < w_r2) && (w_r2 < C_ONE - w_r1));
            end else begin
                w_di = 1'b1;
                w_dj = !(2 * w_r2 < w_r1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= i_x[COORD_W-1] ? -i_x : i_x;
            r_a2 <= i_y[COORD_W-1] ? -i_y : i_y;
            r_sx <= i_x[COORD_W-1];
            r_sy <= i_y[COORD_W-1];
            r_d_a1[1] <= r_a1;
            r_d_sx[1] <= r_sx;
            r_d_sy[1] <= r_sy;
            for (int k = 2; k <= MULQ_LAT; k++) begin
                r_d_a1[k] <= r_d_a1[k-1];
                r_d_sx[k] <= r_d_sx[k-1];
                r_d_sy[k] <= r_d_sy[k-1];
            end
            r_x1  <= r_d_a1[MULQ_LAT] + (w_x2 >>> 1);
            r_x2  <= w_x2;
            r_sx6 <= r_d_sx[MULQ_LAT];
            r_sy6 <= r_d_sy[MULQ_LAT];
            r_i   <= w_m1 + t_coord'(w_di);
            r_j   <= w_m2 + t_coord'(w_dj);
            r_sx7 <= r_sx6;
            r_sy7 <= r_sy6;
            // mirror back into the true quadrant
            unique case ({r_sx7, r_sy7})
                2'b11: begin
                    r_oi <= -r_i;
                    r_oj <= -r_j;
                end
                2'b10: begin
                    r_oi <= r_j - r_i;
                    r_oj <= r_j;
                end
                2'b01: begin
                    r_oi <= r_i - r_j;
                    r_oj <= -r_j;
                end
                default: begin
                    r_oi <= r_i;
                    r_oj <= r_j;
                end
            endcase
        end
    end

    assign o_i = r_oi;
    assign o_j = r_oj;

endmodule

>>> design/hex_ap7_point_quantize.sv
// aperture-7 hex point quantizer, fully pipelined from input beat to output beat
// throughput one point per cycle; a stalled output beat freezes the whole pipeline
// depth is set by the chain of constant multipliers (four stages each) and three snaps
// reset (synchronous, active low) clears the pipeline valid bits and grid_resolution
module hex_ap7_point_quantize (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_cell_i,
    output logic signed [31:0] o_cell_j,
    output logic               o_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hqz_pkg::*;

    // stage count at the output of each section
    localparam int K_B   = 2;
    localparam int K_C   = K_B + MULQ_LAT;
    localparam int K_D   = K_C + ROT_LAT;
    localparam int K_R30 = K_D + ROT_LAT;
    localparam int K_SA  = K_R30 + SNAP_LAT;
    localparam int K_L1  = K_SA + LAT_LAT;
    localparam int K_R3B = K_L1 + ROT_LAT;
    localparam int K_M3  = K_R3B + MULQ_LAT;
    localparam int K_SB  = K_M3 + SNAP_LAT;
    localparam int K_L2  = K_SB + LAT_LAT;
    localparam int K_RTB = K_L2 + ROT_LAT;
    localparam int K_M7  = K_RTB + MULQ_LAT;
    localparam int K_SC  = K_M7 + SNAP_LAT;
    localparam int LAT   = K_SC + 1;
    localparam int DLY   = K_SB - K_SA;
    localparam logic [3:0] ROT_BACK = 4'b1100;

    logic             w_en;
    logic [RES_W-1:0] r_res;
    logic [RES_W-1:0] w_res_c;
    logic             r_vld [1:LAT];
    logic             r_odd [1:K_SB];

    logic signed [31:0] r_a_x, r_a_y;
    logic [RES_W-2:0]   r_a_half;
    t_coord             r_b_x, r_b_y;

    t_coord w_rot_x [4];
    t_coord w_rot_y [4];
    t_coef  w_rot_c [4];
    t_coef  w_rot_s [4];
    t_coord w_rot_rx [4];
    t_coord w_rot_ry [4];

    t_coord w_sc_x [3];
    t_coord w_sc_y [3];
    t_coef  w_sc_c [3];
    t_coord w_sc_px [3];
    t_coord w_sc_py [3];

    t_coord w_lat_i [2];
    t_coord w_lat_j [2];
    t_coord w_lat_x [2];
    t_coord w_lat_y [2];

    t_coord w_sn_x [3];
    t_coord w_sn_y [3];
    t_coord w_sn_i [3];
    t_coord w_sn_j [3];

    t_coord r_dly_i [1:DLY];
    t_coord r_dly_j [1:DLY];

    logic               w_ov_i, w_ov_j;
    logic signed [31:0] r_ci, r_cj;
    logic               r_oor;

    assign w_en    = !r_vld[LAT] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT];

    // configuration port
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_GRID_RES) ? {{(32-RES_W){1'b0}}, r_res} : 32'd0;
    assign w_res_c = (r_res > RES_W'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_GRID_RES)) begin
            r_res <= pwdata[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // input register, power-of-seven scale, and delay lines for the odd bit and the first snap
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x    <= i_point_x;
            r_a_y    <= i_point_y;
            r_a_half <= w_res_c[RES_W-1:1];
            r_odd[1] <= w_res_c[0];
            for (int k = 2; k <= K_SB; k++) r_odd[k] <= r_odd[k-1];
            r_b_x <= t_coord'(r_a_x) * t_coord'($signed({1'b0, pow7(r_a_half)}));
            r_b_y <= t_coord'(r_a_y) * t_coord'($signed({1'b0, pow7(r_a_half)}));
            r_dly_i[1] <= w_sn_i[0];
            r_dly_j[1] <= w_sn_j[0];
            for (int k = 2; k <= DLY; k++) begin
                r_dly_i[k] <= r_dly_i[k-1];
                r_dly_j[k] <= r_dly_j[k-1];
            end
        end
    end

    // datapath wiring
    assign w_sc_x[0] = r_b_x;
    assign w_sc_y[0] = r_b_y;
    assign w_sc_c[0] = r_odd[K_B] ? K_SQRT7 : K_ONE;

    assign w_rot_x[0] = w_sc_px[0];
    assign w_rot_y[0] = w_sc_py[0];
    assign w_rot_c[0] = K_COS_T;
    assign w_rot_s[0] = K_SIN_T;

    // even resolutions pass through this rotation unchanged
    assign w_rot_x[1] = w_rot_rx[0];
    assign w_rot_y[1] = w_rot_ry[0];
    assign w_rot_c[1] = r_odd[K_D] ? K_COS30 : K_ONE;
    assign w_rot_s[1] = r_odd[K_D] ? K_HALF : K_ZERO;

    assign w_sn_x[0] = w_rot_rx[1];
    assign w_sn_y[0] = w_rot_ry[1];

    assign w_lat_i[0] = w_sn_i[0];
    assign w_lat_j[0] = w_sn_j[0];

    assign w_rot_x[2] = w_lat_x[0];
    assign w_rot_y[2] = w_lat_y[0];
    assign w_rot_c[2] = K_COS30;
    assign w_rot_s[2] = K_HALF;

    assign w_sc_x[1] = w_rot_rx[2];
    assign w_sc_y[1] = w_rot_ry[2];
    assign w_sc_c[1] = K_SQRT3;

    assign w_sn_x[1] = w_sc_px[1];
    assign w_sn_y[1] = w_sc_py[1];

    // odd resolutions take the class II result, even ones the delayed first snap
    assign w_lat_i[1] = r_odd[K_SB] ? w_sn_i[1] : r_dly_i[DLY];
    assign w_lat_j[1] = r_odd[K_SB] ? w_sn_j[1] : r_dly_j[DLY];

    assign w_rot_x[3] = w_lat_x[1];
    assign w_rot_y[3] = w_lat_y[1];
    assign w_rot_c[3] = K_COS_T;
    assign w_rot_s[3] = K_SIN_T;

    assign w_sc_x[2] = w_rot_rx[3];
    assign w_sc_y[2] = w_rot_ry[3];
    assign w_sc_c[2] = K_SQRT7;

    assign w_sn_x[2] = w_sc_px[2];
    assign w_sn_y[2] = w_sc_py[2];

    // rotations: lanes are x*c, y*c, x*s, y*s
    for (genvar gr = 0; gr < 4; gr++) begin : g_rot
        t_coord w_p [4];
        t_coord r_rx, r_ry;
        for (genvar gl = 0; gl < 4; gl++) begin : g_lane
            hqz_mulq u_mul (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   ((gl % 2 == 1) ? w_rot_y[gr] : w_rot_x[gr]),
                .i_c   ((gl / 2 == 1) ? w_rot_s[gr] : w_rot_c[gr]),
                .o_p   (w_p[gl])
            );
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (ROT_BACK[gr]) begin
                    r_rx <= w_p[0] - w_p[3];
                    r_ry <= w_p[2] + w_p[1];
                end else begin
                    r_rx <= w_p[0] + w_p[3];
                    r_ry <= w_p[1] - w_p[2];
                end
            end
        end
        assign w_rot_rx[gr] = r_rx;
        assign w_rot_ry[gr] = r_ry;
    end

    for (genvar gs = 0; gs < 3; gs++) begin : g_scale
        hqz_mulq u_mx (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_sc_x[gs]),
            .i_c   (w_sc_c[gs]),
            .o_p   (w_sc_px[gs])
        );
        hqz_mulq u_my (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_sc_y[gs]),
            .i_c   (w_sc_c[gs]),
            .o_p   (w_sc_py[gs])
        );
    end

    // lattice center of (i, j)
    for (genvar gt = 0; gt < 2; gt++) begin : g_lat
        t_coord r_lx, r_ly;
        t_coord r_lxd [1:MULQ_LAT];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lx <= (w_lat_i[gt] <<< FRAC_BITS) - (w_lat_j[gt] <<< (FRAC_BITS - 1));
                r_ly <= w_lat_j[gt] <<< FRAC_BITS;
                r_lxd[1] <= r_lx;
                for (int k = 2; k <= MULQ_LAT; k++) r_lxd[k] <= r_lxd[k-1];
            end
        end
        hqz_mulq u_ly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_ly),
            .i_c   (K_COS30),
            .o_p   (w_lat_y[gt])
        );
        assign w_lat_x[gt] = r_lxd[MULQ_LAT];
    end

    for (genvar gn = 0; gn < 3; gn++) begin : g_snap
        hqz_snap u_snap (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_sn_x[gn]),
            .i_y   (w_sn_y[gn]),
            .o_i   (w_sn_i[gn]),
            .o_j   (w_sn_j[gn])
        );
    end

    // saturate to 32-bit signed
    assign w_ov_i = (w_sn_i[2][COORD_W-1:31] != '0) && (w_sn_i[2][COORD_W-1:31] != '1);
    assign w_ov_j = (w_sn_j[2][COORD_W-1:31] != '0) && (w_sn_j[2][COORD_W-1:31] != '1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ci  <= w_ov_i ? (w_sn_i[2][COORD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : w_sn_i[2][31:0];
            r_cj  <= w_ov_j ? (w_sn_j[2][COORD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : w_sn_j[2][31:0];
            r_oor <= w_ov_i || w_ov_j;
        end
    end

    assign o_cell_i       = r_ci;
    assign o_cell_j       = r_cj;
    assign o_out_of_range = r_oor;

`ifndef SYNTH
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output beat stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[1])
        else $error("accepted beat missing from pipeline");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_GRID_RES))
        |=> (r_res == $past(pwdata[RES_W-1:0])))
        else $error("grid resolution write lost");
`endif

endmodule
